[sv/tte_pkg.sv]
// ----------------------------------------------------------------------------
// tte_pkg
// Shared geometry, character codes and transaction types for the text
// terminal engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Cell address / linear location width: holds CELLS itself and any 11-bit index
    localparam int ADDR_W = ($clog2(CELLS + 1) > 11) ? $clog2(CELLS + 1) : 11;
    // Store index width
    localparam int IDX_W  = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    // Character codes
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    // Opcodes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [15:0] cell_entry;
    } t_out_item;

    // Request to the shared address unit
    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              sub;
    } t_alu_req;

endpackage

`default_nettype wire

[sv/tte_addr_unit.sv]
// ----------------------------------------------------------------------------
// tte_addr_unit
// Shared add/subtract with an in-range compare against the store size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tte_addr_unit (
    input  wire tte_pkg::t_alu_req          i_req,
    output logic [tte_pkg::ADDR_W-1:0]      o_res,
    output logic                            o_lt
);

    always_comb begin
        if (i_req.sub) begin
            o_res = i_req.a - i_req.b;
        end else begin
            o_res = i_req.a + i_req.b;
        end
        o_lt = (o_res < tte_pkg::ADDR_W'(tte_pkg::CELLS));
    end

endmodule

`default_nettype wire

[sv/tte_store.sv]
// ----------------------------------------------------------------------------
// tte_store
// Character cell memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tte_store (
    input  wire                            i_clk,
    input  wire                            i_we,
    input  wire [tte_pkg::IDX_W-1:0]       i_waddr,
    input  wire [15:0]                     i_wdata,
    input  wire                            i_re,
    input  wire [tte_pkg::IDX_W-1:0]       i_raddr,
    output logic [15:0]                    o_rdata
);

    logic [15:0] r_mem [tte_pkg::CELLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[sv/text_terminal_engine.sv]
// ----------------------------------------------------------------------------
// text_terminal_engine
// Character-cell text terminal: cell store, cursor, newline/backspace
// handling with scroll, and single-cell read-back.
// ----------------------------------------------------------------------------
// After reset the engine sweeps the whole store to blank cells (space,
// attribute 7), one cell per cycle, and takes no transaction until the
// sweep is done; attribute writes are taken during the sweep. It then
// works on one transaction at a time. A printable character, a newline or
// a backspace that stays on its row passes the execute and response states
// before its result is raised; a backspace that climbs a row also passes the
// second backspace state, and a read inside the store the read-wait state.
// A put that runs past the last row scrolls: the store is copied up one line
// through its one read port and one write port, one cell per cycle. The
// response state waits until any earlier result is taken. Input ready
// returns in the same cycle that the result is raised. The next transaction
// is accepted while a finished result still waits to be taken. Each result
// carries the linear cursor location after the transaction; a put returns a
// zero cell entry, and a read outside the store returns zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_engine (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input transactions
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire tte_pkg::t_in_item i_in_item,
    // result transactions
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output tte_pkg::t_out_item    o_out_item,
    // attribute register
    input  wire                   i_cfg_we,
    input  wire [7:0]             i_cfg_data
);

    localparam int AW = tte_pkg::ADDR_W;
    localparam int IW = tte_pkg::IDX_W;
    localparam int RW = tte_pkg::ROW_W;
    localparam int CW = tte_pkg::COL_W;

    // sequencer states
    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_EXEC    = 3'd2;
    localparam logic [2:0] S_BS2     = 3'd3;
    localparam logic [2:0] S_RDWAIT  = 3'd4;
    localparam logic [2:0] S_SCPRIME = 3'd5;
    localparam logic [2:0] S_SCROLL  = 3'd6;
    localparam logic [2:0] S_RESP    = 3'd7;

    localparam logic [RW-1:0] LAST_ROW  = RW'(tte_pkg::ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(tte_pkg::COLUMNS - 1);
    localparam logic [IW-1:0] LAST_CELL = IW'(tte_pkg::CELLS - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(tte_pkg::COLUMNS);

    // control state
    logic [2:0]    r_state, n_state;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_loc, n_loc;      // row*COLUMNS + col
    logic [AW-1:0] r_base, n_base;    // row*COLUMNS
    logic [IW-1:0] r_ptr, n_ptr;      // sweep pointer (clear / scroll)
    logic [AW-1:0] r_src, n_src;      // scroll source address
    logic          r_src_ok, n_src_ok;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_attr;

    // payload
    logic          r_op;
    logic [7:0]    r_ch;
    logic [10:0]   r_idx;
    logic [15:0]   r_entry, n_entry;
    tte_pkg::t_out_item r_out, n_out;

    // shared unit and store hookup
    tte_pkg::t_alu_req alu_req;
    logic [AW-1:0] alu_res;
    logic          alu_lt;
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata, mem_rdata;
    logic [15:0]   blank_cell;
    logic          in_fire;

    tte_addr_unit u_alu (
        .i_req (alu_req),
        .o_res (alu_res),
        .o_lt  (alu_lt)
    );

    tte_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign blank_cell  = {r_attr, tte_pkg::CH_SPACE};
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tte_pkg::RESET_ATTR;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_data;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_loc       = r_loc;
        n_base      = r_base;
        n_ptr       = r_ptr;
        n_src       = r_src;
        n_src_ok    = r_src_ok;
        n_entry     = r_entry;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        alu_req.a   = r_loc;
        alu_req.b   = AW'(1);
        alu_req.sub = 1'b0;

        mem_we    = 1'b0;
        mem_waddr = r_loc[IW-1:0];
        mem_wdata = blank_cell;
        mem_re    = 1'b0;
        mem_raddr = alu_res[IW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                // power-on blanking, fixed reset attribute
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = {tte_pkg::RESET_ATTR, tte_pkg::CH_SPACE};
                if (r_ptr == LAST_CELL) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end

            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_entry = 16'd0;
                if (r_op == tte_pkg::OP_READ) begin
                    alu_req.a = AW'(r_idx);
                    alu_req.b = AW'(0);
                    if (alu_lt) begin
                        mem_re  = 1'b1;
                        n_state = S_RDWAIT;
                    end else begin
                        n_state = S_RESP;
                    end
                end else begin
                    case (r_ch)
                        tte_pkg::CH_NEWLINE: begin
                            alu_req.a = r_base;
                            alu_req.b = COLS_A;
                            n_col     = '0;
                            if (r_row == LAST_ROW) begin
                                n_loc   = r_base;
                                n_state = S_SCPRIME;
                            end else begin
                                n_row   = r_row + RW'(1);
                                n_loc   = alu_res;
                                n_base  = alu_res;
                                n_state = S_RESP;
                            end
                        end
                        tte_pkg::CH_BACKSPACE: begin
                            alu_req.sub = 1'b1;
                            mem_we      = 1'b1;
                            mem_waddr   = alu_res[IW-1:0];
                            if (r_col != '0) begin
                                n_col   = r_col - CW'(1);
                                n_loc   = alu_res;
                                n_state = S_RESP;
                            end else if (r_row != '0) begin
                                // climb a row: location just drops by one
                                n_row   = r_row - RW'(1);
                                n_col   = LAST_COL;
                                n_loc   = alu_res;
                                n_state = S_BS2;
                            end else begin
                                // top-left: last column of row 0
                                n_col     = LAST_COL;
                                n_loc     = AW'(tte_pkg::COLUMNS - 1);
                                mem_waddr = IW'(tte_pkg::COLUMNS - 1);
                                n_state   = S_RESP;
                            end
                        end
                        default: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_loc[IW-1:0];
                            mem_wdata = {r_attr, r_ch};
                            if (r_col == LAST_COL) begin
                                n_col = '0;
                                if (r_row == LAST_ROW) begin
                                    n_loc   = r_base;
                                    n_state = S_SCPRIME;
                                end else begin
                                    n_row   = r_row + RW'(1);
                                    n_loc   = alu_res;
                                    n_base  = alu_res;
                                    n_state = S_RESP;
                                end
                            end else begin
                                n_col   = r_col + CW'(1);
                                n_loc   = alu_res;
                                n_state = S_RESP;
                            end
                        end
                    endcase
                end
            end

            S_BS2: begin
                alu_req.a   = r_base;
                alu_req.b   = COLS_A;
                alu_req.sub = 1'b1;
                n_base      = alu_res;
                n_state     = S_RESP;
            end

            S_RDWAIT: begin
                n_entry = mem_rdata;
                n_state = S_RESP;
            end

            S_SCPRIME: begin
                // first source cell is one line down
                alu_req.a = AW'(0);
                alu_req.b = COLS_A;
                mem_re    = alu_lt;
                n_src     = alu_res;
                n_src_ok  = alu_lt;
                n_ptr     = '0;
                n_state   = S_SCROLL;
            end

            S_SCROLL: begin
                // write cell ptr from last cycle's read, fetch the next one;
                // once the source leaves the store it stays out, even if the
                // address counter wraps
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = r_src_ok ? mem_rdata : blank_cell;
                alu_req.a = r_src;
                alu_req.b = AW'(1);
                mem_re    = r_src_ok && alu_lt;
                n_src     = alu_res;
                n_src_ok  = r_src_ok && alu_lt;
                if (r_ptr == LAST_CELL) begin
                    n_state = S_RESP;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end

            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.cursor_pos = 11'(r_loc);
                    n_out.cell_entry = r_entry;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_loc       <= '0;
            r_base      <= '0;
            r_ptr       <= '0;
            r_src       <= '0;
            r_src_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_loc       <= n_loc;
            r_base      <= n_base;
            r_ptr       <= n_ptr;
            r_src       <= n_src;
            r_src_ok    <= n_src_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_out   <= n_out;
        if (in_fire) begin
            r_op  <= i_in_item.opcode;
            r_ch  <= i_in_item.char_code;
            r_idx <= i_in_item.cell_index;
        end
    end

`ifndef SYNTHESIS
    // cursor bookkeeping stays coherent between transactions
    a_loc_coherent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_loc == r_base + AW'(r_col)))
        else $error("cursor location out of step with row base and column");

    a_base_coherent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_base == AW'(r_row) * COLS_A))
        else $error("row base out of step with cursor row");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= LAST_ROW) && (r_col <= LAST_COL))
        else $error("cursor outside the screen");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_EXEC))
        else $error("accepted transaction not executed");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RESP))
        else $error("result raised outside the response step");
`endif

endmodule

`default_nettype wire
